FILE: design/assert_macros.svh
// Assertion macros included by the top-level design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/vndi_pkg.sv
// Package: types and helpers for the vertex dedup indexer.
package vndi_pkg;
    localparam int unsigned CompW = 32;
    localparam int unsigned EntryW = 6 * CompW;
    localparam int unsigned IdxW = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } state_t;

    // IEEE single equality on bit patterns.
    function automatic logic feq(input logic [CompW-1:0] a, input logic [CompW-1:0] b);
        logic nan_a;
        logic nan_b;
        nan_a = (a[30:0] > 31'h7F80_0000);
        nan_b = (b[30:0] > 31'h7F80_0000);
        feq = !nan_a && !nan_b && ((a == b) || ((a[30:0] | b[30:0]) == 31'd0));
    endfunction

    function automatic logic entry_eq(input logic [EntryW-1:0] a,
                                      input logic [EntryW-1:0] b);
        logic r;
        r = 1'b1;
        for (int k = 0; k < 6; k++) begin
            r = r & feq(a[k*CompW +: CompW], b[k*CompW +: CompW]);
        end
        entry_eq = r;
    endfunction
endpackage

FILE: design/vndi_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module vndi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: design/vertex_normal_dedup_indexer_top.sv
// Top level: vertex/normal dedup indexer with a linear-search table.
// Timing: on a hit, the search ends at the matching entry; on an append or overflow, every
//   stored entry is read first (one read per entry).
// Throughput: one corner at a time; a new input is not taken until the result is accepted,
//   and the next input can be taken in the cycle after the output transaction.
// Reset: aresetn synchronous active low clears entry count and FSM; table contents kept.
module vertex_normal_dedup_indexer_top #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
    input  logic         s_tuser,   // start_mesh
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // vertex_index[10:0], is_new, overflow, zero pad
);
    import vndi_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;       // entry being read
    logic [EntryW-1:0] key_reg;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic new_reg, new_next, ovf_reg, ovf_next;
    logic [EntryW-1:0] rd_data;
    logic wr_en;
    logic [AW-1:0] rd_addr;

    // Entry memory; data checked in the cycle after the address is issued.
    vndi_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(key_reg),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {3'd0, ovf_reg, new_reg, idx_reg};
    assign rd_addr  = ptr_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        new_reg <= new_next;
        ovf_reg <= ovf_next;
        if (s_tvalid && s_tready) begin
            key_reg <= s_tdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        new_next   = new_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ptr_next = '0;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        count_next = '0;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // Issue read of entry ptr; nothing stored means straight to append.
                if (ptr_reg == count_reg) begin
                    state_next = ST_WRITE;
                end else begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rd_data holds entry ptr-1.
                if (entry_eq(rd_data, key_reg)) begin
                    idx_next   = IdxW'(ptr_reg - 1'b1);
                    new_next   = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_OUT;
                end else if (ptr_reg == count_reg) begin
                    state_next = ST_WRITE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_WRITE: begin
                if (count_reg == CW'(TABLE_DEPTH)) begin
                    idx_next = IdxW'(TABLE_DEPTH);
                    new_next = 1'b0;
                    ovf_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    idx_next   = IdxW'(count_reg);
                    new_next   = 1'b1;
                    ovf_next   = 1'b0;
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, count_reg <= CW'(TABLE_DEPTH),
                 "count over depth")
    `ASSERT_IMPL(a_ovf_full, aclk, aresetn, m_tvalid && m_tdata[12],
                 count_reg == CW'(TABLE_DEPTH), "overflow while not full")
    `ASSERT_NEXT(a_write_grows, aclk, aresetn, wr_en, count_reg == $past(count_reg) + 1'b1,
                 "write without count step")
    `ASSERT_IMPL(a_new_ovf, aclk, aresetn, m_tvalid, !(m_tdata[11] && m_tdata[12]),
                 "new and overflow")
endmodule
